[hw/rtl/signed_int16_to_ascii_decimal_macros.svh]
// Assertion macros used by the RTL file signed_int16_to_ascii_decimal.sv.
`ifndef SIGNED_INT16_TO_ASCII_DECIMAL_MACROS_SVH
`define SIGNED_INT16_TO_ASCII_DECIMAL_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define S16A_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define S16A_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/s16a_pkg.sv]
package s16a_pkg;

    localparam int unsigned NUM_PLACES = 5;
    localparam int unsigned NUM_STAGES = NUM_PLACES + 1;
    localparam int unsigned MAX_CHARS  = NUM_PLACES + 1;

    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [3:0] DIGIT_MAX  = 4'd9;

    localparam int unsigned PLACE_WEIGHT [NUM_PLACES] = '{10000, 1000, 100, 10, 1};

    typedef logic [3:0] t_digit;

    typedef struct packed {
        logic                        neg;
        logic [15:0]                 rem;
        t_digit [NUM_PLACES-1:0]     digits;
    } t_stage;

    typedef struct packed {
        t_digit      digit;
        logic [15:0] rem;
    } t_digit_res;

    // One decimal digit of rem at the given place, by compare against the
    // nine multiples of the place weight, and the remainder below it.
    function automatic t_digit_res digit_step(input logic [15:0] rem, input int unsigned place);
        t_digit_res  res;
        logic [19:0] thr;
        logic [19:0] sub;
        res.digit = '0;
        sub       = '0;
        for (int m = 1; m <= 9; m++) begin
            thr = 20'(PLACE_WEIGHT[place] * m);
            if ({4'b0, rem} >= thr) begin
                res.digit = 4'(m);
                sub       = thr;
            end
        end
        res.rem = rem - sub[15:0];
        return res;
    endfunction

endpackage

[hw/rtl/s16a_val_if.sv]
interface s16a_val_if;
    logic        valid;
    logic        ready;
    logic [15:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

[hw/rtl/s16a_chr_if.sv]
interface s16a_chr_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

[hw/rtl/signed_int16_to_ascii_decimal.sv]
// Prints one signed 16-bit integer per input item as ASCII decimal text, one
// character per output item: a minus sign for negative values, then one to
// five digits without leading zeros, the final character flagged by is_last.
// A number passes a six-stage pipeline (magnitude, then one stage per decimal
// place) and then a character shift register that drives the output. The
// pipeline takes a new number in every cycle while no stage is stalled; the
// sustained rate is set by the shift register, which sends one character per
// cycle while the output is ready, so each number takes as many output items
// as it has characters (digit count plus one if negative). The first character
// of a number is presented once it has passed every pipeline stage and been loaded into the shift register.
`include "signed_int16_to_ascii_decimal_macros.svh"

module signed_int16_to_ascii_decimal
    import s16a_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    s16a_val_if.sink    i_value_ch,
    s16a_chr_if.source  o_char_ch
);

    t_stage                 r_stg [NUM_STAGES];
    t_stage                 n_stg [NUM_STAGES];
    logic [NUM_STAGES-1:0]  r_vld;
    logic [NUM_STAGES:0]    w_rdy;

    logic [7:0]             r_chr [MAX_CHARS];
    logic [2:0]             r_left;

    logic [7:0]             w_txt [MAX_CHARS];
    logic [2:0]             w_cnt;
    logic                   w_out_fire;
    logic                   w_load;

    assign w_out_fire = o_char_ch.valid && o_char_ch.ready;
    assign w_load     = w_rdy[NUM_STAGES] && r_vld[NUM_STAGES-1];

    always_comb begin
        w_rdy[NUM_STAGES] = (r_left == 3'd0) || ((r_left == 3'd1) && o_char_ch.ready);
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign i_value_ch.ready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_value_ch.valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        t_digit_res dres;
        n_stg[0].neg    = i_value_ch.value[15];
        n_stg[0].rem    = i_value_ch.value[15] ? (~i_value_ch.value + 16'd1)
                                               : i_value_ch.value;
        n_stg[0].digits = '0;
        for (int k = 1; k < NUM_STAGES; k++) begin
            dres                          = digit_step(r_stg[k-1].rem, k - 1);
            n_stg[k]                      = r_stg[k-1];
            n_stg[k].digits[NUM_PLACES-k] = dres.digit;
            n_stg[k].rem                  = dres.rem;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (w_rdy[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    // Digits are stored most significant first at the high index.
    always_comb begin
        logic [2:0] nd;
        logic [2:0] lead;
        logic [2:0] idx;
        logic [7:0] dsel [NUM_PLACES];
        t_stage     s;
        s = r_stg[NUM_STAGES-1];
        priority if (s.digits[4] != '0) begin
            nd = 3'd5;
        end else if (s.digits[3] != '0) begin
            nd = 3'd4;
        end else if (s.digits[2] != '0) begin
            nd = 3'd3;
        end else if (s.digits[1] != '0) begin
            nd = 3'd2;
        end else begin
            nd = 3'd1;
        end
        lead = 3'd5 - nd;
        for (int j = 0; j < NUM_PLACES; j++) begin
            idx = 3'(j) + lead;
            if (idx < 3'd5) begin
                dsel[j] = CHAR_ZERO + {4'b0, s.digits[3'd4 - idx]};
            end else begin
                dsel[j] = CHAR_ZERO;
            end
        end
        for (int j = 0; j < MAX_CHARS; j++) begin
            w_txt[j] = CHAR_ZERO;
        end
        if (s.neg) begin
            w_txt[0] = CHAR_MINUS;
            for (int j = 0; j < NUM_PLACES; j++) begin
                w_txt[j+1] = dsel[j];
            end
        end else begin
            for (int j = 0; j < NUM_PLACES; j++) begin
                w_txt[j] = dsel[j];
            end
        end
        w_cnt = nd + {2'b0, s.neg};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (w_rdy[NUM_STAGES]) begin
            r_left <= r_vld[NUM_STAGES-1] ? w_cnt : 3'd0;
        end else if (w_out_fire) begin
            r_left <= r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[NUM_STAGES]) begin
            for (int j = 0; j < MAX_CHARS; j++) begin
                r_chr[j] <= w_txt[j];
            end
        end else if (w_out_fire) begin
            for (int j = 0; j < MAX_CHARS - 1; j++) begin
                r_chr[j] <= r_chr[j+1];
            end
            r_chr[MAX_CHARS-1] <= CHAR_ZERO;
        end
    end

    assign o_char_ch.valid     = (r_left != 3'd0);
    assign o_char_ch.char_code = r_chr[0];
    assign o_char_ch.is_last   = (r_left == 3'd1);

    `S16A_ASSERT_NOW(a_char_range, o_char_ch.valid, (r_chr[0] == CHAR_MINUS) || ((r_chr[0] >= CHAR_ZERO) && (r_chr[0] <= CHAR_ZERO + {4'b0, DIGIT_MAX})), "character out of range")
    `S16A_ASSERT_NOW(a_left_bound, 1'b1, r_left <= 3'(MAX_CHARS), "character count above six")
    `S16A_ASSERT_NOW(a_no_lead_zero, w_load && !r_stg[NUM_STAGES-1].neg && (w_cnt > 3'd1), w_txt[0] != CHAR_ZERO, "leading zero emitted")
    `S16A_ASSERT_NEXT(a_stage_hold, r_vld[NUM_STAGES-1] && !w_rdy[NUM_STAGES], r_vld[NUM_STAGES-1] && $stable(r_stg[NUM_STAGES-1]), "stalled stage lost its item")
    `S16A_ASSERT_NEXT(a_minus_first, w_load && r_stg[NUM_STAGES-1].neg, r_chr[0] == CHAR_MINUS, "negative number without leading minus")

endmodule
